/* src/cplu_pkg.sv */
// ============================================================================
// Contact process lattice update: shared definitions
// Widths, command and event codes, and the control and status words that
// pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package cplu_pkg;

    // Default torus side length.
    localparam int GRID_SIDE_DEF = 256;

    // Fixed field widths.
    localparam int COORD_W  = 8;
    localparam int CMD_W    = 2;
    localparam int DIR_W    = 2;
    localparam int DRAW_W   = 16;
    localparam int CHOICE_W = 3;
    localparam int EVENT_W  = 2;
    localparam int PROB_W   = 17;
    localparam int CFG_IDX_W = 1;

    // Probability one as a fraction over 65536.
    localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

    // Highest valid pair choice.
    localparam logic [CHOICE_W-1:0] CHOICE_MAX = 3'd5;
    // Number of outer neighbors kept on the site side of the pair.
    localparam logic [CHOICE_W-1:0] SITE_SIDE_COUNT = 3'd3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    // Positions in the up, down, right, left neighbor order.
    localparam logic [1:0] POS_UP    = 2'd0;
    localparam logic [1:0] POS_DOWN  = 2'd1;
    localparam logic [1:0] POS_RIGHT = 2'd2;
    localparam logic [1:0] POS_LEFT  = 2'd3;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE       = 2'd0;
    localparam logic [EVENT_W-1:0] EV_NBR_BORN   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_SITE_EMPTY = 2'd2;
    localparam logic [EVENT_W-1:0] EV_PAIR_BORN  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_PROB = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_PROB  = 1'd1;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;       // clearing pass: write zero at the sweep address
        logic load;        // capture the incoming word, read the site cell
        logic site_phase;  // site cell on the RAM output
        logic nbr_phase;   // neighbor cell on the RAM output
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;  // sweep address is at the last cell
        logic is_update;   // captured command is an update step
        logic site_occ;    // site cell read back as occupied
    } dp_status_t;

endpackage : cplu_pkg

`default_nettype wire

/* src/cplu_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module cplu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : cplu_ram

`default_nettype wire

/* src/cplu_ctrl.sv */
// ============================================================================
// Contact process lattice update: controller
// Sequences the clearing pass after reset, the site phase of each command
// and the neighbor phase of occupied-site updates; drives busy and done.
// ============================================================================
`default_nettype none

module cplu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire cplu_pkg::dp_status_t status,
    output cplu_pkg::ctrl_cmd_t       cmd,
    output logic                      busy,
    output logic                      done
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SITE,
        ST_NBR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SITE;
                end
            end
            ST_SITE:
            begin
                cmd.site_phase = 1'b1;
                if (status.is_update && status.site_occ)
                begin
                    state_next = ST_NBR;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_NBR:
            begin
                cmd.nbr_phase = 1'b1;
                state_next    = ST_IDLE;
                done_next     = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule : cplu_ctrl

`default_nettype wire

/* src/cplu_datapath.sv */
// ============================================================================
// Contact process lattice update: datapath
// Holds the lattice RAM, the probability registers, the captured command
// word, the neighbor arithmetic and the result registers.
// ============================================================================
`default_nettype none

module cplu_datapath #(
    parameter int GRID_SIDE = cplu_pkg::GRID_SIDE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cplu_pkg::ctrl_cmd_t               cmd,
    output cplu_pkg::dp_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [cplu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cplu_pkg::PROB_W-1:0]       cfg_data,
    input  wire logic [cplu_pkg::CMD_W-1:0]        command,
    input  wire logic [cplu_pkg::COORD_W-1:0]      site_row,
    input  wire logic [cplu_pkg::COORD_W-1:0]      site_col,
    input  wire logic [cplu_pkg::DIR_W-1:0]        direction,
    input  wire logic [cplu_pkg::DRAW_W-1:0]       draw_main,
    input  wire logic [cplu_pkg::DRAW_W-1:0]       draw_second,
    input  wire logic [cplu_pkg::CHOICE_W-1:0]     pair_choice,
    input  wire logic                              write_value,
    output logic      [cplu_pkg::EVENT_W-1:0]      event_res,
    output logic                                   cell_value,
    output logic      [cplu_pkg::COORD_W-1:0]      changed_row,
    output logic      [cplu_pkg::COORD_W-1:0]      changed_col
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IN_RANGE = 1 << cplu_pkg::COORD_W;

    // Reduction of an input coordinate modulo the side, built at elaboration.
    function automatic logic [IN_RANGE*CW-1:0] build_mod_tab();
        logic [IN_RANGE*CW-1:0] tab;
        int unsigned            v;
        tab = '0;
        v   = 0;
        for (int i = 0; i < IN_RANGE; i++)
        begin
            tab[i*CW +: CW] = CW'(v);
            v = (v + 1 == GRID_SIDE) ? 0 : v + 1;
        end
        return tab;
    endfunction

    localparam logic [IN_RANGE*CW-1:0] MOD_TAB = build_mod_tab();

    function automatic logic [CW-1:0] up_of(input logic [CW-1:0] v);
        return (v == '0) ? CW'(GRID_SIDE - 1) : v - 1'b1;
    endfunction

    function automatic logic [CW-1:0] down_of(input logic [CW-1:0] v);
        return (v == CW'(GRID_SIDE - 1)) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
        return AW'(r) * AW'(GRID_SIDE) + AW'(c);
    endfunction

    // Configuration registers.
    logic [cplu_pkg::PROB_W-1:0] birth_reg;
    logic [cplu_pkg::PROB_W-1:0] pair_reg;

    // Captured command word.
    logic [cplu_pkg::CMD_W-1:0]    cmd_reg;
    logic [CW-1:0]                 row_reg;
    logic [CW-1:0]                 col_reg;
    logic [cplu_pkg::DIR_W-1:0]    dir_reg;
    logic [cplu_pkg::DRAW_W-1:0]   d1_reg;
    logic [cplu_pkg::DRAW_W-1:0]   d2_reg;
    logic [cplu_pkg::CHOICE_W-1:0] pc_reg;
    logic                          wv_reg;
    logic                          old_reg;
    logic [CW-1:0]                 nb_row_reg;
    logic [CW-1:0]                 nb_col_reg;

    // Clearing sweep address.
    logic [AW-1:0] clear_cnt_reg;
    logic [AW-1:0] clear_cnt_next;

    // Result registers.
    logic [cplu_pkg::EVENT_W-1:0] event_reg;
    logic [cplu_pkg::EVENT_W-1:0] event_next;
    logic                         value_reg;
    logic                         value_next;
    logic [cplu_pkg::COORD_W-1:0] crow_reg;
    logic [cplu_pkg::COORD_W-1:0] crow_next;
    logic [cplu_pkg::COORD_W-1:0] ccol_reg;
    logic [cplu_pkg::COORD_W-1:0] ccol_next;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    // Combinational helpers.
    logic [CW-1:0] in_row_red;
    logic [CW-1:0] in_col_red;
    logic [CW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic [AW-1:0] site_addr;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] tgt_addr;
    logic [1:0]    ex_site;
    logic [1:0]    ex_nbr;
    logic [CW-1:0] s_row [4];
    logic [CW-1:0] s_col [4];
    logic [CW-1:0] n_row [4];
    logic [CW-1:0] n_col [4];
    logic [cplu_pkg::CHOICE_W-1:0] pc_sat;
    logic [1:0]    pc_low;
    logic [1:0]    pick;
    logic [CW-1:0] tgt_row;
    logic [CW-1:0] tgt_col;
    logic [cplu_pkg::PROB_W-1:0] p_sat;
    logic [cplu_pkg::PROB_W-1:0] q_sat;
    logic [cplu_pkg::PROB_W-1:0] keep_thr;
    logic          d1_lt_p;
    logic          d1_lt_q;
    logic          d2_lt_keep;

    // Input coordinate reduction and lattice addresses.
    assign in_row_red = MOD_TAB[site_row*CW +: CW];
    assign in_col_red = MOD_TAB[site_col*CW +: CW];
    assign site_addr  = addr_of(row_reg, col_reg);
    assign nb_addr    = addr_of(nb_row_reg, nb_col_reg);
    assign tgt_addr   = addr_of(tgt_row, tgt_col);

    // Neighbor chosen by the direction, and the partner positions to skip.
    always_comb
    begin
        nb_row  = row_reg;
        nb_col  = col_reg;
        ex_site = cplu_pkg::POS_RIGHT;
        ex_nbr  = cplu_pkg::POS_LEFT;
        case (dir_reg)
            cplu_pkg::DIR_UP:
            begin
                nb_row  = up_of(row_reg);
                ex_site = cplu_pkg::POS_UP;
                ex_nbr  = cplu_pkg::POS_DOWN;
            end
            cplu_pkg::DIR_DOWN:
            begin
                nb_row  = down_of(row_reg);
                ex_site = cplu_pkg::POS_DOWN;
                ex_nbr  = cplu_pkg::POS_UP;
            end
            cplu_pkg::DIR_LEFT:
            begin
                nb_col  = up_of(col_reg);
                ex_site = cplu_pkg::POS_LEFT;
                ex_nbr  = cplu_pkg::POS_RIGHT;
            end
            default:
            begin
                nb_col  = down_of(col_reg);
                ex_site = cplu_pkg::POS_RIGHT;
                ex_nbr  = cplu_pkg::POS_LEFT;
            end
        endcase
    end

    // Outer neighbors in up, down, right, left order for both pair members.
    always_comb
    begin
        s_row[cplu_pkg::POS_UP]    = up_of(row_reg);
        s_col[cplu_pkg::POS_UP]    = col_reg;
        s_row[cplu_pkg::POS_DOWN]  = down_of(row_reg);
        s_col[cplu_pkg::POS_DOWN]  = col_reg;
        s_row[cplu_pkg::POS_RIGHT] = row_reg;
        s_col[cplu_pkg::POS_RIGHT] = down_of(col_reg);
        s_row[cplu_pkg::POS_LEFT]  = row_reg;
        s_col[cplu_pkg::POS_LEFT]  = up_of(col_reg);
        n_row[cplu_pkg::POS_UP]    = up_of(nb_row_reg);
        n_col[cplu_pkg::POS_UP]    = nb_col_reg;
        n_row[cplu_pkg::POS_DOWN]  = down_of(nb_row_reg);
        n_col[cplu_pkg::POS_DOWN]  = nb_col_reg;
        n_row[cplu_pkg::POS_RIGHT] = nb_row_reg;
        n_col[cplu_pkg::POS_RIGHT] = down_of(nb_col_reg);
        n_row[cplu_pkg::POS_LEFT]  = nb_row_reg;
        n_col[cplu_pkg::POS_LEFT]  = up_of(nb_col_reg);
    end

    // Pair target: the chosen entry of the six, skipping each partner.
    always_comb
    begin
        pc_sat = (pc_reg > cplu_pkg::CHOICE_MAX) ? cplu_pkg::CHOICE_MAX : pc_reg;
        if (pc_sat < cplu_pkg::SITE_SIDE_COUNT)
        begin
            pc_low  = pc_sat[1:0];
            pick    = (pc_low < ex_site) ? pc_low : pc_low + 2'd1;
            tgt_row = s_row[pick];
            tgt_col = s_col[pick];
        end
        else
        begin
            pc_low  = 2'(pc_sat - cplu_pkg::SITE_SIDE_COUNT);
            pick    = (pc_low < ex_nbr) ? pc_low : pc_low + 2'd1;
            tgt_row = n_row[pick];
            tgt_col = n_col[pick];
        end
    end

    // Probability thresholds, saturated at one.
    assign p_sat      = (birth_reg > cplu_pkg::PROB_ONE) ? cplu_pkg::PROB_ONE : birth_reg;
    assign q_sat      = (pair_reg > cplu_pkg::PROB_ONE) ? cplu_pkg::PROB_ONE : pair_reg;
    assign keep_thr   = cplu_pkg::PROB_ONE - p_sat;
    assign d1_lt_p    = {1'b0, d1_reg} < p_sat;
    assign d1_lt_q    = {1'b0, d1_reg} < q_sat;
    assign d2_lt_keep = {1'b0, d2_reg} < keep_thr;

    // RAM read address: the site on load, the neighbor in the site phase.
    assign ram_raddr = cmd.load ? addr_of(in_row_red, in_col_red) : addr_of(nb_row, nb_col);

    // Lattice writes, sweep counter and result words.
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = site_addr;
        ram_wdata      = 1'b0;
        clear_cnt_next = clear_cnt_reg;
        event_next     = event_reg;
        value_next     = value_reg;
        crow_next      = crow_reg;
        ccol_next      = ccol_reg;

        if (cmd.clear)
        begin
            ram_we         = 1'b1;
            ram_waddr      = clear_cnt_reg;
            clear_cnt_next = clear_cnt_reg + 1'b1;
        end

        // Site cell on the RAM output: all but updates on occupied sites finish here.
        if (cmd.site_phase)
        begin
            event_next = cplu_pkg::EV_NONE;
            value_next = ram_rdata;
            crow_next  = cplu_pkg::COORD_W'(row_reg);
            ccol_next  = cplu_pkg::COORD_W'(col_reg);
            if (cmd_reg == cplu_pkg::CMD_WRITE)
            begin
                ram_we    = 1'b1;
                ram_wdata = wv_reg;
            end
        end

        // Neighbor cell on the RAM output: decide the update.
        if (cmd.nbr_phase)
        begin
            value_next = old_reg;
            event_next = cplu_pkg::EV_NONE;
            crow_next  = cplu_pkg::COORD_W'(row_reg);
            ccol_next  = cplu_pkg::COORD_W'(col_reg);
            if (!ram_rdata)
            begin
                ram_we = 1'b1;
                if (d1_lt_p)
                begin
                    ram_waddr  = nb_addr;
                    ram_wdata  = 1'b1;
                    event_next = cplu_pkg::EV_NBR_BORN;
                    crow_next  = cplu_pkg::COORD_W'(nb_row_reg);
                    ccol_next  = cplu_pkg::COORD_W'(nb_col_reg);
                end
                else
                begin
                    event_next = cplu_pkg::EV_SITE_EMPTY;
                end
            end
            else if (d1_lt_q)
            begin
                ram_we     = 1'b1;
                ram_waddr  = tgt_addr;
                ram_wdata  = 1'b1;
                event_next = cplu_pkg::EV_PAIR_BORN;
                crow_next  = cplu_pkg::COORD_W'(tgt_row);
                ccol_next  = cplu_pkg::COORD_W'(tgt_col);
            end
            else if (d2_lt_keep)
            begin
                ram_we     = 1'b1;
                event_next = cplu_pkg::EV_SITE_EMPTY;
            end
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_reg     <= '0;
            pair_reg      <= '0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    cplu_pkg::REG_BIRTH_PROB: birth_reg <= cfg_data;
                    cplu_pkg::REG_PAIR_PROB:  pair_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            row_reg <= in_row_red;
            col_reg <= in_col_red;
            dir_reg <= direction;
            d1_reg  <= draw_main;
            d2_reg  <= draw_second;
            pc_reg  <= pair_choice;
            wv_reg  <= write_value;
        end
        if (cmd.site_phase)
        begin
            old_reg    <= ram_rdata;
            nb_row_reg <= nb_row;
            nb_col_reg <= nb_col;
        end
        event_reg <= event_next;
        value_reg <= value_next;
        crow_reg  <= crow_next;
        ccol_reg  <= ccol_next;
    end

    // Lattice storage.
    cplu_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_lattice (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Status back to the controller.
    assign status.clear_last = (clear_cnt_reg == AW'(DEPTH - 1));
    assign status.is_update  = (cmd_reg == cplu_pkg::CMD_UPDATE);
    assign status.site_occ   = ram_rdata;

    assign event_res   = event_reg;
    assign cell_value  = value_reg;
    assign changed_row = crow_reg;
    assign changed_col = ccol_reg;

endmodule : cplu_datapath

`default_nettype wire

/* src/contact_process_lattice_update_unit.sv */
// ============================================================================
// Contact process lattice update unit
// Torus of one-bit cells with pair-contact update, write and read commands.
// ============================================================================
// An update on an occupied site goes from accept to result through one
// lattice RAM read for the site, one for the neighbor, then one write.
// Updates on empty sites, reads and writes finish in the site phase. done is
// high for one cycle per result; a new command may be accepted in that same
// cycle. After reset busy stays high while the RAM is cleared one cell per
// cycle; configuration writes are taken throughout.
`default_nettype none

module contact_process_lattice_update_unit #(
    parameter int GRID_SIDE = cplu_pkg::GRID_SIDE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    output logic                                   done,
    input  wire logic                              cfg_we,
    input  wire logic [cplu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cplu_pkg::PROB_W-1:0]       cfg_data,
    input  wire logic [cplu_pkg::CMD_W-1:0]        command,
    input  wire logic [cplu_pkg::COORD_W-1:0]      site_row,
    input  wire logic [cplu_pkg::COORD_W-1:0]      site_col,
    input  wire logic [cplu_pkg::DIR_W-1:0]        direction,
    input  wire logic [cplu_pkg::DRAW_W-1:0]       draw_main,
    input  wire logic [cplu_pkg::DRAW_W-1:0]       draw_second,
    input  wire logic [cplu_pkg::CHOICE_W-1:0]     pair_choice,
    input  wire logic                              write_value,
    output logic      [cplu_pkg::EVENT_W-1:0]      event_res,
    output logic                                   cell_value,
    output logic      [cplu_pkg::COORD_W-1:0]      changed_row,
    output logic      [cplu_pkg::COORD_W-1:0]      changed_col
);

    cplu_pkg::ctrl_cmd_t  cmd;
    cplu_pkg::dp_status_t status;

    // Sequencer.
    cplu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Lattice, arithmetic and result registers.
    cplu_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .site_row    (site_row),
        .site_col    (site_col),
        .direction   (direction),
        .draw_main   (draw_main),
        .draw_second (draw_second),
        .pair_choice (pair_choice),
        .write_value (write_value),
        .event_res   (event_res),
        .cell_value  (cell_value),
        .changed_row (changed_row),
        .changed_col (changed_col)
    );

endmodule : contact_process_lattice_update_unit

`default_nettype wire

/* sim/tb_top.sv */
// ============================================================================
// Contact process lattice update unit: testbench
// Drives update, write, read and spare commands through the start/busy
// handshake and compares every done word with a lattice predictor held in a
// small scoreboard class. Both probabilities are swept through several
// settings, including zero, one and values above one.
// ============================================================================

module tb_top;
    import cplu_pkg::*;

    // Spare command code: behaves like a read.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int GRID_CELLS   = GRID_SIDE_DEF * GRID_SIDE_DEF;
    localparam int SEGMENTS     = 9;
    localparam int SEG_WORDS    = 100;
    // The clearing pass alone sweeps all 65536 cells without any accept.
    localparam int STALL_LIMIT  = 200000;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [DIR_W-1:0]    dir;
        logic [DRAW_W-1:0]   d1;
        logic [DRAW_W-1:0]   d2;
        logic [CHOICE_W-1:0] pc;
        logic                wv;
    } cmd_word_t;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic               occ;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } outcome_t;

    // Scoreboard: lattice predictor plus the queue of predicted outcomes.
    class lattice_scoreboard;
        bit                cells [GRID_CELLS];
        logic [PROB_W-1:0] birth_reg;
        logic [PROB_W-1:0] pair_reg;
        outcome_t          outcome_q [$];
        int                fails;

        function new();
            birth_reg = '0;
            pair_reg  = '0;
            fails     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PROB_W-1:0] data);
            if (idx == REG_BIRTH_PROB)
                birth_reg = data;
            else if (idx == REG_PAIR_PROB)
                pair_reg = data;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Apply one command to the predicted lattice and return its outcome.
        function outcome_t apply_command(cmd_word_t w);
            logic [PROB_W-1:0]  p;
            logic [PROB_W-1:0]  q;
            logic [COORD_W-1:0] nr;
            logic [COORD_W-1:0] nc;
            logic [COORD_W-1:0] cand_r [8];
            logic [COORD_W-1:0] cand_c [8];
            logic [COORD_W-1:0] pick_r [6];
            logic [COORD_W-1:0] pick_c [6];
            int                 n;
            int                 k;
            int                 pc;
            bit                 skip;
            outcome_t           res;

            p = (birth_reg > PROB_ONE) ? PROB_ONE : birth_reg;
            q = (pair_reg > PROB_ONE) ? PROB_ONE : pair_reg;
            res.ev  = EV_NONE;
            res.occ = cells[{w.row, w.col}];
            res.row = w.row;
            res.col = w.col;
            nr = w.row;
            nc = w.col;

            if (w.cmd == CMD_WRITE) begin
                cells[{w.row, w.col}] = w.wv;
            end
            else if (w.cmd == CMD_UPDATE && res.occ) begin
                // The side is 256, so 8-bit wrap gives the torus.
                case (w.dir)
                    DIR_UP:   nr = w.row - 8'd1;
                    DIR_DOWN: nr = w.row + 8'd1;
                    DIR_LEFT: nc = w.col - 8'd1;
                    default:  nc = w.col + 8'd1;
                endcase
                if (!cells[{nr, nc}]) begin
                    if (w.d1 < p) begin
                        cells[{nr, nc}] = 1'b1;
                        res.ev  = EV_NBR_BORN;
                        res.row = nr;
                        res.col = nc;
                    end
                    else begin
                        cells[{w.row, w.col}] = 1'b0;
                        res.ev = EV_SITE_EMPTY;
                    end
                end
                else if (w.d1 < q) begin
                    // Outer neighbors: up, down, right, left of the site, then
                    // the same of the neighbor, each side skipping its partner.
                    cand_r[0] = w.row - 8'd1; cand_c[0] = w.col;
                    cand_r[1] = w.row + 8'd1; cand_c[1] = w.col;
                    cand_r[2] = w.row;        cand_c[2] = w.col + 8'd1;
                    cand_r[3] = w.row;        cand_c[3] = w.col - 8'd1;
                    cand_r[4] = nr - 8'd1;    cand_c[4] = nc;
                    cand_r[5] = nr + 8'd1;    cand_c[5] = nc;
                    cand_r[6] = nr;           cand_c[6] = nc + 8'd1;
                    cand_r[7] = nr;           cand_c[7] = nc - 8'd1;
                    n = 0;
                    for (k = 0; k < 8; k++) begin
                        if (k < 4)
                            skip = ({cand_r[k], cand_c[k]} == {nr, nc});
                        else
                            skip = ({cand_r[k], cand_c[k]} == {w.row, w.col});
                        if (!skip && n < 6) begin
                            pick_r[n] = cand_r[k];
                            pick_c[n] = cand_c[k];
                            n++;
                        end
                    end
                    pc = (w.pc > CHOICE_MAX) ? int'(CHOICE_MAX) : int'(w.pc);
                    if (n > 0) begin
                        if (pc >= n)
                            pc = n - 1;
                        cells[{pick_r[pc], pick_c[pc]}] = 1'b1;
                        res.ev  = EV_PAIR_BORN;
                        res.row = pick_r[pc];
                        res.col = pick_c[pc];
                    end
                end
                else if ({1'b0, w.d2} < PROB_ONE - p) begin
                    cells[{w.row, w.col}] = 1'b0;
                    res.ev = EV_SITE_EMPTY;
                end
            end
            return res;
        endfunction

        function void note_word(cmd_word_t w);
            outcome_q.push_back(apply_command(w));
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;

            if (outcome_q.size() == 0) begin
                $error("result word with no command outstanding: event_res %0d", got.ev);
                fails++;
                return;
            end
            want = outcome_q.pop_front();
            if (got.ev !== want.ev) begin
                $error("event_res mismatch: expected %0d, actual %0d", want.ev, got.ev);
                fails++;
            end
            if (got.occ !== want.occ) begin
                $error("cell_value mismatch: expected %0d, actual %0d", want.occ, got.occ);
                fails++;
            end
            if (got.row !== want.row) begin
                $error("changed_row mismatch: expected %0d, actual %0d", want.row, got.row);
                fails++;
            end
            if (got.col !== want.col) begin
                $error("changed_col mismatch: expected %0d, actual %0d", want.col, got.col);
                fails++;
            end
        endfunction
    endclass

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic                    done;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [PROB_W-1:0]       cfg_data    = '0;
    logic [CMD_W-1:0]        command     = CMD_READ;
    logic [COORD_W-1:0]      site_row    = '0;
    logic [COORD_W-1:0]      site_col    = '0;
    logic [DIR_W-1:0]        direction   = DIR_UP;
    logic [DRAW_W-1:0]       draw_main   = '0;
    logic [DRAW_W-1:0]       draw_second = '0;
    logic [CHOICE_W-1:0]     pair_choice = '0;
    logic                    write_value = 1'b0;
    logic [EVENT_W-1:0]      event_res;
    logic                    cell_value;
    logic [COORD_W-1:0]      changed_row;
    logic [COORD_W-1:0]      changed_col;

    cmd_word_t          bus_word;
    outcome_t           seen_result;
    lattice_scoreboard  sb = new();
    int                 idle_pct = 0;
    int                 stall_cycles = 0;

    assign bus_word = {command, site_row, site_col, direction,
                       draw_main, draw_second, pair_choice, write_value};
    assign seen_result = {event_res, cell_value, changed_row, changed_col};

    contact_process_lattice_update_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .site_row    (site_row),
        .site_col    (site_col),
        .direction   (direction),
        .draw_main   (draw_main),
        .draw_second (draw_second),
        .pair_choice (pair_choice),
        .write_value (write_value),
        .event_res   (event_res),
        .cell_value  (cell_value),
        .changed_row (changed_row),
        .changed_col (changed_col)
    );

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: results first, then the accepted word, then register writes.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(seen_result);
            if (start && !busy)
                sb.note_word(bus_word);
            if (cfg_we)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog on cycles with no accepted word in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("contact_process_lattice_update_unit verification failed");
            $finish;
        end
    end

    function automatic cmd_word_t make_word(
        logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
        logic [DIR_W-1:0] dir, logic [DRAW_W-1:0] d1, logic [DRAW_W-1:0] d2,
        logic [CHOICE_W-1:0] pc, logic wv);
        return {cmd, row, col, dir, d1, d2, pc, wv};
    endfunction

    // Draw near a threshold half the time so both sides of a compare are hit.
    function automatic logic [DRAW_W-1:0] pick_draw(int thresh);
        int v;

        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 65535);
            1:       v = $urandom_range(0, 1) ? 65535 : 0;
            default: v = thresh + int'($urandom_range(0, 4)) - 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[DRAW_W-1:0];
    endfunction

    // Random command, mostly inside a 6x6 window so cells meet their neighbors.
    function automatic cmd_word_t random_word(logic [COORD_W-1:0] base_r,
                                              logic [COORD_W-1:0] base_c);
        cmd_word_t w;
        int        sel;
        int        p;

        sel = $urandom_range(0, 99);
        if (sel < 55)
            w.cmd = CMD_UPDATE;
        else if (sel < 80)
            w.cmd = CMD_WRITE;
        else if (sel < 95)
            w.cmd = CMD_READ;
        else
            w.cmd = CMD_SPARE;
        if ($urandom_range(0, 99) < 85) begin
            w.row = base_r + 8'($urandom_range(0, 5));
            w.col = base_c + 8'($urandom_range(0, 5));
        end
        else begin
            w.row = 8'($urandom_range(0, 255));
            w.col = 8'($urandom_range(0, 255));
        end
        p = (sb.birth_reg > PROB_ONE) ? int'(PROB_ONE) : int'(sb.birth_reg);
        w.dir = 2'($urandom_range(0, 3));
        w.d1  = pick_draw($urandom_range(0, 1) ? p : int'(sb.pair_reg));
        w.d2  = pick_draw(int'(PROB_ONE) - p);
        w.pc  = 3'($urandom_range(0, 7));
        w.wv  = ($urandom_range(0, 9) < 7);
        return w;
    endfunction

    // Present one command word and hold start until busy is seen low.
    task automatic drive_word(cmd_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        {command, site_row, site_col, direction,
         draw_main, draw_second, pair_choice, write_value} = w;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PROB_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Drop start and wait for every outstanding result word.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [PROB_W-1:0]  birth_val;
        logic [PROB_W-1:0]  pair_val;
        logic [COORD_W-1:0] base_r;
        logic [COORD_W-1:0] base_c;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers are taken during the clearing pass.
        write_reg(REG_BIRTH_PROB, 17'd32768);
        write_reg(REG_PAIR_PROB, 17'd32768);

        // Directed commands around the corner of the torus.
        idle_pct = 29;
        drive_word(make_word(CMD_READ, 8'd0, 8'd0, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b0));
        // Update on an empty site changes nothing.
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b0));
        drive_word(make_word(CMD_WRITE, 8'd0, 8'd0, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b1));
        drive_word(make_word(CMD_WRITE, 8'd0, 8'd0, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b1));
        drive_word(make_word(CMD_SPARE, 8'd0, 8'd0, DIR_UP, 16'hFFFF, 16'hFFFF, 3'd7,
                             1'b1));
        // Neighbor birth across the top edge, then site emptied going left.
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b0));
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_LEFT, 16'hFFFF, 16'd0, 3'd0,
                             1'b0));
        drive_word(make_word(CMD_WRITE, 8'd0, 8'd0, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b1));
        // Draw just below the birth probability.
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN, 16'd32767, 16'd0, 3'd0,
                             1'b0));
        // Pair birth onto a cell that is already occupied.
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN, 16'd0, 16'd0, 3'd0, 1'b0));
        // Pair choice above five saturates.
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN, 16'd0, 16'd0, 3'd7, 1'b0));
        // Occupied pair with neither pair birth nor emptying.
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN, 16'd32768, 16'hFFFF, 3'd0,
                             1'b0));
        drive_word(make_word(CMD_UPDATE, 8'd0, 8'd0, DIR_DOWN, 16'hFFFF, 16'd0, 3'd0,
                             1'b0));
        drive_word(make_word(CMD_WRITE, 8'd255, 8'd255, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b1));
        drive_word(make_word(CMD_UPDATE, 8'd255, 8'd255, DIR_RIGHT, 16'hFFFF, 16'd32767,
                             3'd0, 1'b0));
        drive_word(make_word(CMD_WRITE, 8'd255, 8'd255, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b1));
        drive_word(make_word(CMD_UPDATE, 8'd255, 8'd255, DIR_DOWN, 16'd0, 16'd0, 3'd0,
                             1'b0));
        drive_word(make_word(CMD_UPDATE, 8'd255, 8'd255, DIR_DOWN, 16'd0, 16'd0, 3'd6,
                             1'b0));
        drive_word(make_word(CMD_READ, 8'd255, 8'd255, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b0));
        drive_word(make_word(CMD_READ, 8'd0, 8'd255, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b0));
        drive_word(make_word(CMD_WRITE, 8'd0, 8'd255, DIR_UP, 16'd0, 16'd0, 3'd0, 1'b0));
        drive_word(make_word(CMD_UPDATE, 8'd170, 8'd85, DIR_RIGHT, 16'h5555, 16'hAAAA,
                             3'd5, 1'b1));
        drive_word(make_word(CMD_READ, 8'd85, 8'd170, DIR_LEFT, 16'hAAAA, 16'h5555,
                             3'd2, 1'b0));

        // Random segments, each with its own probabilities and sender idling.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg)
                0: begin birth_val = 17'd32768;   pair_val = 17'd32768;   end
                1: begin birth_val = 17'd0;       pair_val = 17'd0;       end
                2: begin birth_val = PROB_ONE;    pair_val = PROB_ONE;    end
                3: begin birth_val = 17'h1FFFF;   pair_val = 17'h1FFFF;   end
                4: begin birth_val = PROB_ONE;    pair_val = 17'd0;       end
                5: begin birth_val = 17'd0;       pair_val = PROB_ONE;    end
                6: begin
                    birth_val = 17'($urandom_range(0, 65536));
                    pair_val  = 17'($urandom_range(0, 65536));
                end
                7: begin birth_val = 17'd10000;   pair_val = 17'd50000;   end
                default: begin
                    birth_val = 17'($urandom_range(0, 17'h1FFFF));
                    pair_val  = 17'($urandom_range(0, 17'h1FFFF));
                end
            endcase
            write_reg(REG_BIRTH_PROB, birth_val);
            write_reg(REG_PAIR_PROB, pair_val);
            case (seg % 3)
                0:       idle_pct = 29;
                1:       idle_pct = 70;
                default: idle_pct = 0;
            endcase
            if (seg == 0) begin
                base_r = 8'd253;
                base_c = 8'd253;
            end
            else begin
                base_r = 8'($urandom_range(0, 255));
                base_c = 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < SEG_WORDS; i++)
                drive_word(random_word(base_r, base_c));
        end

        // Let the last results arrive, then wait out any stray strobes.
        drain();
        repeat (6) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("contact_process_lattice_update_unit verification clean");
        else
            $display("contact_process_lattice_update_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
src/cplu_pkg.sv
src/cplu_ram.sv
src/cplu_ctrl.sv
src/cplu_datapath.sv
src/contact_process_lattice_update_unit.sv
sim/tb_top.sv
